// ----- hdl/dtq_pkg.sv -----
// shared types and codes of the deferred event timer queue
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned HandleW = 8;
  localparam int unsigned OrderW  = 16;

  // input kind codes
  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  // result status codes
  localparam logic STATUS_EXPIRED  = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_TICK,
    OP_POP
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  // one chain slot
  typedef struct packed {
    logic               valid;
    logic               expired;
    logic [TimeW-1:0]   remaining;
    logic [HandleW-1:0] handle;
    logic [OrderW-1:0]  order;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_e           op;
    logic [TimeW-1:0]   delay;
    logic [HandleW-1:0] handle;
    logic [OrderW-1:0]  order;
    logic [TimeW-1:0]   elapsed;
  } cmd_t;

endpackage

// ----- hdl/dtq_in_if.sv -----
// input channel of the timer queue: schedule and tick beats
`timescale 1ns / 1ps
interface dtq_in_if;
  import dtq_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [TimeW-1:0]   delay;
  logic [HandleW-1:0] handle;
  logic [TimeW-1:0]   elapsed;

  modport source (output valid, kind, delay, handle, elapsed, input ready);
  modport sink (input valid, kind, delay, handle, elapsed, output ready);
endinterface

// ----- hdl/dtq_out_if.sv -----
// output channel of the timer queue: fired and rejected handles
`timescale 1ns / 1ps
interface dtq_out_if;
  import dtq_pkg::*;

  logic               valid;
  logic               ready;
  logic [HandleW-1:0] fired_handle;
  logic               status;
  logic               last;

  modport source (output valid, fired_handle, status, last, input ready);
  modport sink (input valid, fired_handle, status, last, output ready);
endinterface

// ----- hdl/dtq_cell.sv -----
// one slot of the sorted chain of pending events
`timescale 1ns / 1ps
module dtq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dtq_pkg::cmd_t   cmd_i,
  input  dtq_pkg::entry_t prev_i,
  input  logic            prev_keep_i,
  input  dtq_pkg::entry_t next_i,
  output dtq_pkg::entry_t entry_o,
  output logic            keep_o
);
  import dtq_pkg::*;

  entry_t entry_q, entry_d;

  // entry stays in place when it is due no later than the new one
  assign keep_o = entry_q.valid && (entry_q.remaining <= cmd_i.delay);

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (!keep_o) begin
          if (prev_keep_i) begin
            entry_d.valid     = 1'b1;
            entry_d.expired   = 1'b0;
            entry_d.remaining = cmd_i.delay;
            entry_d.handle    = cmd_i.handle;
            entry_d.order     = cmd_i.order;
          end else begin
            entry_d = prev_i;
          end
        end
      end
      OP_TICK: begin
        entry_d.expired   = entry_q.valid && (cmd_i.elapsed > entry_q.remaining);
        entry_d.remaining = entry_q.remaining - cmd_i.elapsed;
      end
      OP_POP:  entry_d = next_i;
      default: entry_d = entry_q;
    endcase
  end

  // slot register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule

// ----- hdl/dtq_chain.sv -----
// row of cells kept sorted by remaining time, head at index zero
`timescale 1ns / 1ps
module dtq_chain #(
  parameter int unsigned Depth = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dtq_pkg::cmd_t   cmd_i,
  output dtq_pkg::entry_t head_o,
  output dtq_pkg::entry_t second_o,
  output logic            full_o
);
  import dtq_pkg::*;

  entry_t cells [Depth];
  logic   keep  [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    entry_t prev_entry;
    entry_t next_entry;
    logic   prev_keep;

    // neighbors, empty past both ends; the slot before the head reads as kept
    if (g == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_keep  = 1'b1;
    end else begin : g_mid
      assign prev_entry = cells[g-1];
      assign prev_keep  = keep[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = cells[g+1];
    end

    dtq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .prev_i      (prev_entry),
      .prev_keep_i (prev_keep),
      .next_i      (next_entry),
      .entry_o     (cells[g]),
      .keep_o      (keep[g])
    );
  end

  assign head_o   = cells[0];
  assign second_o = cells[1];
  assign full_o   = cells[Depth-1].valid;
endmodule

// ----- hdl/deferred_event_timer_queue_unit.sv -----
// top level of the deferred event timer queue
//
// in_i carries one beat per request: kind selects schedule (store handle with
// delay) or tick (advance time by elapsed). out_o delivers results: expired
// handles with status expired, or one rejected result when a schedule finds
// all QUEUE_DEPTH slots taken. The final result of a request has last set.
// A schedule is placed in sorted position at once; a rejected schedule shows
// its result on out_o in the next cycle. A tick first ages every slot, then
// shifts each expired event out of the head of the cell chain in turn (the
// head is still looked at when nothing expired); no new request is taken
// until that drain ends.
// Results pass through one output register, so a request is accepted while
// a result waits if that result is taken in the same cycle. When the
// receiver stalls, the drain pauses with the chain unchanged.
// Reset empties the queue and clears the arrival counter at once.
`timescale 1ns / 1ps
module deferred_event_timer_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtq_in_if.sink    in_i,
  dtq_out_if.source out_o
);
  import dtq_pkg::*;

  state_e             state_q, state_d;
  cmd_t               cmd;
  entry_t             head, second;
  logic               full;
  logic               in_fire;
  logic               out_free;
  logic               out_load;
  logic [HandleW-1:0] out_handle_d;
  logic               out_status_d;
  logic               out_last_d;
  logic               out_valid_q;
  logic [HandleW-1:0] out_handle_q;
  logic               out_status_q;
  logic               out_last_q;
  logic [OrderW-1:0]  seq_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;

  dtq_chain #(
    .Depth (QUEUE_DEPTH)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .head_o   (head),
    .second_o (second),
    .full_o   (full)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.kind == KIND_TICK)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(head.valid && head.expired)) begin
          state_d = ST_IDLE;
        end else if (out_free && !(second.valid && second.expired)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine: chain command and result load
  always_comb begin
    in_i.ready    = 1'b0;
    cmd.op        = OP_HOLD;
    cmd.delay     = in_i.delay;
    cmd.handle    = in_i.handle;
    cmd.order     = seq_q;
    cmd.elapsed   = in_i.elapsed;
    out_load      = 1'b0;
    out_handle_d  = head.handle;
    out_status_d  = STATUS_EXPIRED;
    out_last_d    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = out_free;
        if (in_i.valid && out_free) begin
          if (in_i.kind == KIND_TICK) begin
            cmd.op = OP_TICK;
          end else if (full) begin
            out_load     = 1'b1;
            out_handle_d = in_i.handle;
            out_status_d = STATUS_REJECTED;
          end else begin
            cmd.op = OP_INSERT;
          end
        end
      end
      ST_DRAIN: begin
        if (head.valid && head.expired && out_free) begin
          cmd.op     = OP_POP;
          out_load   = 1'b1;
          out_last_d = !(second.valid && second.expired);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      seq_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd.op == OP_INSERT) seq_q <= seq_q + OrderW'(1);
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_handle_q <= out_handle_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fired_handle = out_handle_q;
  assign out_o.status       = out_status_q;
  assign out_o.last         = out_last_q;

  // a pop only ever removes an expired head
  a_pop_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_POP) |-> (head.valid && head.expired))
    else $error("pop of a head that has not expired");

  // a rejected schedule only when every slot is taken
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (out_status_d == STATUS_REJECTED)) |-> full)
    else $error("schedule rejected with free slots");

  // an insert always leaves a valid head
  a_insert_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_INSERT) |=> head.valid)
    else $error("chain empty after insert");
endmodule

// ----- bench/tb.sv -----
// self-checking testbench of the deferred event timer queue
`timescale 1ns / 1ps
module tb;
  import dtq_pkg::*;

  localparam int Depth = 16;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic               status;
    logic               last;
  } fire_t;

  // timer chain predictor and the queue of handles it expects to see
  class timer_scoreboard;
    logic [TimeW-1:0]   rem_ticks[Depth];
    logic [HandleW-1:0] slot_handle[Depth];
    int                 occupied = 0;
    fire_t              expected_fires[$];
    int                 mismatches = 0;

    // a beat was taken on the input side: advance the chain and queue results
    function void note_input(logic kind, logic [TimeW-1:0] delay,
                             logic [HandleW-1:0] handle, logic [TimeW-1:0] elapsed);
      int    pos;
      int    fired;
      fire_t f;
      pos   = 0;
      fired = 0;
      if (kind == KIND_SCHEDULE) begin
        if (occupied >= Depth) begin
          f.handle = handle;
          f.status = STATUS_REJECTED;
          f.last   = 1'b1;
          expected_fires = {expected_fires, f};
          return;
        end
        // new entry goes behind all entries due no later than it
        while (pos < occupied && rem_ticks[pos] <= delay) pos++;
        for (int i = occupied; i > pos; i--) begin
          rem_ticks[i]   = rem_ticks[i-1];
          slot_handle[i] = slot_handle[i-1];
        end
        rem_ticks[pos]   = delay;
        slot_handle[pos] = handle;
        occupied++;
      end else begin
        // expired entries are the front of the sorted chain
        while (fired < occupied && elapsed > rem_ticks[fired]) fired++;
        for (int i = 0; i < fired; i++) begin
          f.handle = slot_handle[i];
          f.status = STATUS_EXPIRED;
          f.last   = (i == fired - 1);
          expected_fires = {expected_fires, f};
        end
        for (int i = fired; i < occupied; i++) begin
          rem_ticks[i-fired]   = rem_ticks[i] - elapsed;
          slot_handle[i-fired] = slot_handle[i];
        end
        occupied -= fired;
      end
    endfunction

    // a result beat was taken: compare with the oldest expectation
    function void check_result(logic [HandleW-1:0] handle, logic status, logic last);
      fire_t f;
      if (expected_fires.size() == 0) begin
        $display("%0t: unexpected result handle %0h status %0b last %0b",
                 $time, handle, status, last);
        mismatches++;
        return;
      end
      f = expected_fires.pop_front();
      if (handle !== f.handle) begin
        $display("%0t: fired_handle expected %0h actual %0h", $time, f.handle, handle);
        mismatches++;
      end
      if (status !== f.status) begin
        $display("%0t: status expected %0b actual %0b", $time, f.status, status);
        mismatches++;
      end
      if (last !== f.last) begin
        $display("%0t: last expected %0b actual %0b", $time, f.last, last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_fires.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dtq_in_if  in_bus ();
  dtq_out_if out_bus ();

  deferred_event_timer_queue_unit #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  timer_scoreboard sb = new();

  int src_idle  = 31;
  int sink_idle = 61;
  bit hold_go   = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // result side: check taken beats, stall at random or for a long hold
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.fired_handle, out_bus.status, out_bus.last);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= sink_idle);
      end
    end
  end

  // offer one beat after a random gap and wait until it is taken
  task automatic send_beat(input logic kind, input logic [TimeW-1:0] delay,
                           input logic [HandleW-1:0] handle,
                           input logic [TimeW-1:0] elapsed);
    while ($urandom_range(0, 99) < src_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.kind    <= kind;
    in_bus.delay   <= delay;
    in_bus.handle  <= handle;
    in_bus.elapsed <= elapsed;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_input(kind, delay, handle, elapsed);
  endtask

  // unused fields carry junk so every input bit toggles
  task automatic schedule(input logic [TimeW-1:0] delay, input logic [HandleW-1:0] handle);
    send_beat(KIND_SCHEDULE, delay, handle, TimeW'($urandom));
  endtask

  task automatic tick(input logic [TimeW-1:0] elapsed);
    send_beat(KIND_TICK, TimeW'($urandom), HandleW'($urandom), elapsed);
  endtask

  function automatic logic [TimeW-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return TimeW'($urandom);
      default: return TimeW'($urandom_range(0, 400));
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TimeW'($urandom);
      default: return TimeW'($urandom_range(0, 120));
    endcase
  endfunction

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 55)
        schedule(pick_delay(), HandleW'($urandom_range(0, 255)));
      else
        tick(pick_elapsed());
    end
  endtask

  // stimulus and end of run
  initial begin
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.kind    <= KIND_SCHEDULE;
    in_bus.delay   <= '0;
    in_bus.handle  <= '0;
    in_bus.elapsed <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, extremes, ties, zero elapsed, full queue
    tick(16'd5);
    schedule(16'd0, 8'h00);
    schedule(16'hFFFF, 8'hFF);
    schedule(16'd100, 8'h11);
    schedule(16'd100, 8'h22);
    tick(16'd0);
    tick(16'd1);
    tick(16'd100);
    for (int i = 0; i < 15; i++)
      schedule((i == 7) ? 16'hFFFF : TimeW'((i % 5) * 4096), HandleW'(8'h40 + i));
    schedule(16'd3, 8'hA5);
    tick(16'hFFFF);

    random_items(60);

    // long receiver hold while the queue fills and rejects back up
    hold_go = 1'b1;
    for (int i = 0; i < 20; i++)
      schedule(pick_delay(), HandleW'($urandom_range(0, 255)));
    tick(16'hFFFF);

    src_idle  = 61;
    sink_idle = 31;
    random_items(70);

    src_idle  = 0;
    sink_idle = 0;
    random_items(70);

    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dtq_pkg.sv
hdl/dtq_in_if.sv
hdl/dtq_out_if.sv
hdl/dtq_cell.sv
hdl/dtq_chain.sv
hdl/deferred_event_timer_queue_unit.sv
bench/tb.sv
